// ----- rtl/core/two_button_gesture_turn_signal_ctrl_unit_assert.svh -----
// Assertion macros for the gesture controller.
`ifndef TWO_BUTTON_GESTURE_TURN_SIGNAL_CTRL_UNIT_ASSERT_SVH
`define TWO_BUTTON_GESTURE_TURN_SIGNAL_CTRL_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define TBG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TBG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/tbg_pkg.sv -----
// ----------------------------------------------------------------------------
// tbg_pkg
// Shared types and constants of the two-button gesture controller.
// ----------------------------------------------------------------------------
package tbg_pkg;
  localparam logic [3:0] G_NONE = 4'd0;
  localparam logic [3:0] G_MAIN = 4'd1;
  localparam logic [3:0] G_EXTRA = 4'd2;
  localparam logic [3:0] G_SOS = 4'd3;
  localparam logic [3:0] G_LEFT = 4'd4;
  localparam logic [3:0] G_RIGHT = 4'd5;
  localparam logic [3:0] G_LFORCE = 4'd6;
  localparam logic [3:0] G_RFORCE = 4'd7;
  localparam logic [3:0] G_LIGHTER = 4'd8;
  localparam logic [3:0] G_DARKER = 4'd9;
  localparam logic [3:0] G_INVALID = 4'd10;

  localparam logic [2:0] R_HOLD = 3'd0;
  localparam logic [2:0] R_GAP = 3'd1;
  localparam logic [2:0] R_BON = 3'd2;
  localparam logic [2:0] R_BOFF = 3'd3;
  localparam logic [2:0] R_TOUT = 3'd4;
  localparam logic [2:0] R_STEP = 3'd5;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic       done;
    logic [3:0] gesture;
  } tbg_cmd_t;

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    return (v == SAT16) ? SAT16 : v + 16'd1;
  endfunction
endpackage

// ----- rtl/core/two_button_gesture_turn_signal_ctrl_unit.sv -----
// ----------------------------------------------------------------------------
// two_button_gesture_turn_signal_ctrl_unit
// Gesture controller for a light with turn signals, one word per tick.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tdata: left_level, right_level
// out_    | master    | tdata: gesture and lamp state
// cfg_    | write     | six timing and step registers
// One word is accepted every cycle while the two-entry command queue has room.
// The front scans and decodes a word in the cycle it is accepted; the back
// updates its state when it pops the command into the output register.
// A result word passes through the command queue and then the output register.
// Reset is synchronous and active low; no clearing pass is needed.
`include "two_button_gesture_turn_signal_ctrl_unit_assert.svh"
module two_button_gesture_turn_signal_ctrl_unit import tbg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] left_level, [1] right_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // gesture_code, main_on, extra_on, sos_on,
                                  // left_turn_on, right_turn_on, lamp_lit,
                                  // light_level, scene_mode
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] hold_r, gap_r, tout_r;
  logic [14:0] bon_r, boff_r;
  logic [7:0]  step_r;
  tbg_cmd_t    cmd;
  logic [3:0]  q_r [2];
  logic [1:0]  cnt_r;
  logic        wp_r, rp_r;
  logic        acc, pop;
  logic [19:0] res;
  logic [19:0] ob_r;
  logic        ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 16'd800; gap_r <= 16'd500; bon_r <= 15'd600; boff_r <= 15'd400;
      tout_r <= 16'd20000; step_r <= 8'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        R_HOLD: hold_r <= cfg_data;
        R_GAP:  gap_r <= cfg_data;
        R_BON:  bon_r <= cfg_data[14:0];
        R_BOFF: boff_r <= cfg_data[14:0];
        R_TOUT: tout_r <= cfg_data;
        R_STEP: step_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign acc = in_tvalid && in_tready;
  assign pop = (cnt_r != 2'd0) && (!ov_r || out_tready);

  tbg_front u_front (
    .clk(clk), .rst_n(rst_n), .step(acc),
    .left_level(in_tdata[0]), .right_level(in_tdata[1]),
    .hold_ticks(hold_r), .gap_ticks(gap_r), .cmd(cmd)
  );

  tbg_back u_back (
    .clk(clk), .rst_n(rst_n), .step(pop), .gesture(q_r[rp_r]),
    .blink_on(bon_r), .blink_off(boff_r), .tout(tout_r), .bstep(step_r),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (acc) q_r[wp_r] <= cmd.gesture;
    if (pop) ob_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0; wp_r <= 1'b0; rp_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (acc) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, acc} - {1'b0, pop};
      if (pop) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {4'd0, ob_r};

  `TBG_ASSERT_IMP(a_no_overflow, cnt_r == 2'd2, !acc)
  `TBG_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `TBG_ASSERT_NXT(a_pop_shows, pop, out_tvalid)
endmodule

// ----- rtl/core/tbg_front.sv -----
// ----------------------------------------------------------------------------
// tbg_front
// Button scanning and gesture decoding; issues one command word per tick.
// ----------------------------------------------------------------------------
module tbg_front import tbg_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic           left_level,
  input  logic           right_level,
  input  logic [15:0]    hold_ticks,
  input  logic [15:0]    gap_ticks,
  output tbg_cmd_t       cmd
);
  logic        lprev_r, lprev_nxt, rprev_r, rprev_nxt;
  logic [15:0] lsince_r, lsince_nxt, rsince_r, rsince_nxt;
  logic [3:0]  lps_r, lps_nxt, rps_r, rps_nxt;
  logic        lfin, rfin;
  logic [15:0] le, re;
  logic [3:0]  lps_s, rps_s;

  function automatic logic [3:0] press(input logic [3:0] ps);
    if (ps[1]) return 4'd4;
    else if (ps[0]) return 4'd2;
    else if (ps == 4'd0) return 4'd1;
    else return 4'd15;
  endfunction

  function automatic logic [3:0] decode(input logic [3:0] l, input logic [3:0] r);
    if (l == 4'd15 || r == 4'd15) return G_INVALID;
    if (l[0] && r[0]) return G_MAIN;
    if (l[1] && r[1]) return G_EXTRA;
    if (l[2] && r[2]) return G_SOS;
    if (r[1] && l == 4'd0) return G_RFORCE;
    if (r[3] || r[2]) return G_LIGHTER;
    if (l[1] && r == 4'd0) return G_LFORCE;
    if (l[3] || l[2]) return G_DARKER;
    if (l[0] && r == 4'd0) return G_LEFT;
    if (r[0] && l == 4'd0) return G_RIGHT;
    return G_NONE;
  endfunction

  always_comb begin
    lprev_nxt = lprev_r; rprev_nxt = rprev_r;
    le = lsince_r; re = rsince_r;
    lps_s = lps_r; rps_s = rps_r;
    lfin = 1'b0; rfin = 1'b0;
    if (left_level != lprev_r) begin
      le = 16'd0; lprev_nxt = left_level;
      if (!left_level) lps_s = press(lps_r);
    end else if (!left_level && lsince_r > hold_ticks) begin
      lps_s = lps_r | 4'd8;
    end
    if (lps_s != 4'd0) begin
      lfin = (left_level && le > gap_ticks) || lps_s[3] || lps_s == 4'd15;
    end
    lsince_nxt = inc_sat(le);
    rsince_nxt = rsince_r;
    if (!lfin) begin
      if (right_level != rprev_r) begin
        re = 16'd0; rprev_nxt = right_level;
        if (!right_level) rps_s = press(rps_r);
      end else if (!right_level && rsince_r > hold_ticks) begin
        rps_s = rps_r | 4'd8;
      end
      if (rps_s != 4'd0) begin
        rfin = (right_level && re > gap_ticks) || rps_s[3] || rps_s == 4'd15;
      end
      rsince_nxt = inc_sat(re);
    end
    cmd.done = lfin || rfin;
    cmd.gesture = cmd.done ? decode(lps_s, rps_s) : G_NONE;
    lps_nxt = cmd.done ? 4'd0 : lps_s;
    rps_nxt = cmd.done ? 4'd0 : rps_s;
    if (cmd.done) begin
      lsince_nxt = 16'd0; rsince_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lprev_r <= 1'b1; rprev_r <= 1'b1;
      lsince_r <= 16'd0; rsince_r <= 16'd0;
      lps_r <= 4'd0; rps_r <= 4'd0;
    end else if (step) begin
      lprev_r <= lprev_nxt; rprev_r <= rprev_nxt;
      lsince_r <= lsince_nxt; rsince_r <= rsince_nxt;
      lps_r <= lps_nxt; rps_r <= rps_nxt;
    end
  end
endmodule

// ----- rtl/core/tbg_back.sv -----
// ----------------------------------------------------------------------------
// tbg_back
// Applies gesture commands to mode, brightness, scene and blink state.
// ----------------------------------------------------------------------------
module tbg_back import tbg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [3:0]  gesture,
  input  logic [14:0] blink_on,
  input  logic [14:0] blink_off,
  input  logic [15:0] tout,
  input  logic [7:0]  bstep,
  output logic [19:0] res
);
  logic [4:0]  flags_r, flags_nxt;
  logic [7:0]  lvl_r, lvl_nxt;
  logic [1:0]  scn_r, scn_nxt;
  logic [15:0] age_r, age_nxt, ph_r, ph_nxt;
  logic        was, sos, lit;
  logic [8:0]  sum;
  logic [1:0]  scene;

  always_comb begin
    flags_nxt = flags_r; lvl_nxt = lvl_r; scn_nxt = scn_r;
    age_nxt = inc_sat(age_r); ph_nxt = inc_sat(ph_r);
    was = |flags_r[4:2]; sos = flags_r[2];
    sum = {1'b0, lvl_r} + {1'b0, bstep};
    unique case (gesture)
      G_MAIN, G_EXTRA: begin
        if (sos) flags_nxt[2] = 1'b0;
        else if (gesture == G_MAIN) flags_nxt[0] = ~flags_r[0];
        else flags_nxt[1] = ~flags_r[1];
        scn_nxt = 2'd0; age_nxt = 16'd0;
        if (flags_nxt[4:2] == 3'd0) ph_nxt = SAT16;
      end
      G_SOS: begin
        flags_nxt[2] = ~sos; flags_nxt[4:3] = 2'b00;
        scn_nxt = sos ? 2'd0 : 2'd3; age_nxt = 16'd0;
        if (flags_nxt[4:2] == 3'd0) ph_nxt = SAT16;
      end
      G_LEFT, G_RIGHT: begin
        flags_nxt[4:3] = 2'b00;
        if (gesture == G_LEFT) flags_nxt[3] = ~was;
        else flags_nxt[4] = ~was;
        scn_nxt = was ? 2'd0 : ((gesture == G_LEFT) ? 2'd1 : 2'd2);
        age_nxt = 16'd0;
        if (flags_nxt[4:2] == 3'd0) ph_nxt = SAT16;
      end
      G_LFORCE, G_RFORCE: begin
        flags_nxt[4:3] = (gesture == G_LFORCE) ? 2'b01 : 2'b10;
        if (!sos) begin
          scn_nxt = (gesture == G_LFORCE) ? 2'd1 : 2'd2; age_nxt = 16'd0;
        end
      end
      G_LIGHTER: begin
        lvl_nxt = sum[8] ? 8'd255 : sum[7:0];
        flags_nxt[1] = 1'b1;
      end
      G_DARKER: begin
        lvl_nxt = (lvl_r > bstep) ? lvl_r - bstep : 8'd0;
        flags_nxt[1] = (lvl_r > bstep);
      end
      default: begin
      end
    endcase
    if ({1'b0, ph_nxt} > ({2'b0, blink_on} + {2'b0, blink_off})) ph_nxt = 16'd0;
    lit = (|flags_nxt[4:2]) && (ph_nxt < {1'b0, blink_on});
    if (scn_nxt != 2'd0 && age_nxt > tout && !flags_nxt[2]) begin
      flags_nxt[4:3] = 2'b00; scn_nxt = 2'd0; age_nxt = 16'd0;
      if (flags_nxt[4:2] == 3'd0) ph_nxt = SAT16;
    end
    if (flags_nxt[2]) scene = 2'd3;
    else if (flags_nxt[3]) scene = 2'd1;
    else if (flags_nxt[4]) scene = 2'd2;
    else scene = scn_nxt;
    res = {scene, lvl_nxt, lit, flags_nxt[4], flags_nxt[3], flags_nxt[2],
           flags_nxt[1], flags_nxt[0], gesture};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= 5'd0; lvl_r <= 8'd100; scn_r <= 2'd0;
      age_r <= 16'd0; ph_r <= 16'd0;
    end else if (step) begin
      flags_r <= flags_nxt; lvl_r <= lvl_nxt; scn_r <= scn_nxt;
      age_r <= age_nxt; ph_r <= ph_nxt;
    end
  end
endmodule

// ----- dv/two_button_gesture_turn_signal_ctrl_unit_test.sv -----
// ----------------------------------------------------------------------------
// two_button_gesture_turn_signal_ctrl_unit_test
// Drives button-level ticks into the gesture controller with random gaps on
// both sides, predicts every result word from a behavioural copy of the
// controller and compares each one field by field, across several register
// settings.
// ----------------------------------------------------------------------------
module two_button_gesture_turn_signal_ctrl_unit_test;
  import tbg_pkg::*;

  typedef struct packed {
    logic [1:0] scene;
    logic [7:0] level;
    logic       lamp_lit;
    logic       right_on;
    logic       left_on;
    logic       sos_on;
    logic       extra_on;
    logic       main_on;
    logic [3:0] gesture;
  } lamp_word_t;

  typedef struct {
    logic [1:0] lv;
    logic       chk;
    lamp_word_t want;
  } stim_row_t;

  localparam logic [4:0] F_MAIN = 5'd1, F_EXTRA = 5'd2, F_SOS = 5'd4,
                         F_LEFT = 5'd8, F_RIGHT = 5'd16;
  localparam logic [3:0] P_ONE = 4'd1, P_TWO = 4'd2, P_THREE = 4'd4,
                         P_HOLD = 4'd8, P_BAD = 4'd15;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready, cfg_we;
  logic [7:0]  in_tdata;
  logic [23:0] out_tdata;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  two_button_gesture_turn_signal_ctrl_unit dut (.*);

  logic [15:0] hold_t, gap_t, tout_t;
  logic [14:0] bon_t, boff_t;
  logic [7:0]  step_v;
  logic [1:0]  prev_lv;
  logic [15:0] since [2];
  logic [3:0]  press [2];
  logic [4:0]  flags;
  logic [8:0]  bright;
  logic [1:0]  scene_st;
  logic [15:0] age, phase;

  lamp_word_t  expected_words[$];
  logic        hold_off;
  int          mismatches;
  bit          failed;

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit signalling_now();
    return (flags & (F_SOS | F_LEFT | F_RIGHT)) != 0;
  endfunction

  function automatic void go_scene(logic [1:0] s);
    scene_st = s;
    age = 0;
    if (!signalling_now()) phase = 16'hFFFF;
  endfunction

  task automatic reset_model();
    hold_t = 800; gap_t = 500; bon_t = 600; boff_t = 400; tout_t = 20000;
    step_v = 30; prev_lv = 2'b11; since[0] = 0; since[1] = 0;
    press[0] = 0; press[1] = 0; flags = 0; bright = 100; scene_st = 0;
    age = 0; phase = 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      R_HOLD: hold_t = val;
      R_GAP:  gap_t = val;
      R_BON:  bon_t = val[14:0];
      R_BOFF: boff_t = val[14:0];
      R_TOUT: tout_t = val;
      R_STEP: step_v = val[7:0];
      default: ;
    endcase
  endtask

  function automatic bit scan(int b, logic lvl);
    logic [15:0] e;
    bit fin;
    e = since[b];
    fin = 0;
    if (lvl != prev_lv[b]) begin
      e = 0;
      prev_lv[b] = lvl;
      if (!lvl) begin
        if (press[b] & P_TWO) press[b] = P_THREE;
        else if (press[b] & P_ONE) press[b] = P_TWO;
        else if (press[b] == 0) press[b] = P_ONE;
        else press[b] = P_BAD;
      end
    end else if (!lvl && e > hold_t) begin
      press[b] = press[b] | P_HOLD;
    end
    if (press[b] != 0) begin
      if (lvl && e > gap_t) fin = 1;
      if ((press[b] & P_HOLD) || press[b] == P_BAD) fin = 1;
    end
    since[b] = bump(e);
    return fin;
  endfunction

  function automatic logic [3:0] decode_gesture(logic [3:0] l, logic [3:0] r);
    if (l == P_BAD || r == P_BAD) return G_INVALID;
    if ((l & P_ONE) && (r & P_ONE)) return G_MAIN;
    if ((l & P_TWO) && (r & P_TWO)) return G_EXTRA;
    if ((l & P_THREE) && (r & P_THREE)) return G_SOS;
    if ((r & P_TWO) && l == 0) return G_RFORCE;
    if ((r & P_HOLD) || (r & P_THREE)) return G_LIGHTER;
    if ((l & P_TWO) && r == 0) return G_LFORCE;
    if ((l & P_HOLD) || (l & P_THREE)) return G_DARKER;
    if ((l & P_ONE) && r == 0) return G_LEFT;
    if ((r & P_ONE) && l == 0) return G_RIGHT;
    return G_NONE;
  endfunction

  function automatic void apply_gesture(logic [3:0] g);
    bit was, sos;
    was = signalling_now();
    sos = (flags & F_SOS) != 0;
    case (g)
      G_MAIN, G_EXTRA: begin
        if (sos) flags &= ~F_SOS;
        else flags ^= (g == G_MAIN) ? F_MAIN : F_EXTRA;
        go_scene(0);
      end
      G_SOS: begin
        flags = sos ? (flags & ~F_SOS) : (flags | F_SOS);
        flags &= ~(F_LEFT | F_RIGHT);
        go_scene(sos ? 2'd0 : 2'd3);
      end
      G_LEFT, G_RIGHT: begin
        flags &= ~(F_LEFT | F_RIGHT);
        if (!was) flags |= (g == G_LEFT) ? F_LEFT : F_RIGHT;
        go_scene(was ? 2'd0 : ((g == G_LEFT) ? 2'd1 : 2'd2));
      end
      G_LFORCE, G_RFORCE: begin
        flags &= ~(F_LEFT | F_RIGHT);
        flags |= (g == G_LFORCE) ? F_LEFT : F_RIGHT;
        if (!sos) go_scene((g == G_LFORCE) ? 2'd1 : 2'd2);
      end
      G_LIGHTER: begin
        bright = bright + step_v;
        if (bright > 255) bright = 255;
        flags |= F_EXTRA;
      end
      G_DARKER: begin
        bright = (bright > step_v) ? bright - step_v : 9'd0;
        if (bright != 0) flags |= F_EXTRA;
        else flags &= ~F_EXTRA;
      end
      default: ;
    endcase
  endfunction

  function automatic lamp_word_t predict_tick(logic [1:0] lv);
    lamp_word_t w;
    logic [3:0] g;
    bit done, lit;
    g = G_NONE;
    age = bump(age);
    phase = bump(phase);
    done = scan(0, lv[0]);
    if (!done) done = scan(1, lv[1]);
    if (done) begin
      g = decode_gesture(press[0], press[1]);
      apply_gesture(g);
      press[0] = 0; press[1] = 0; since[0] = 0; since[1] = 0;
    end
    if ({1'b0, phase} > {2'b0, bon_t} + {2'b0, boff_t}) phase = 0;
    lit = signalling_now() && phase < {1'b0, bon_t};
    if (scene_st != 0 && age > tout_t && !(flags & F_SOS)) begin
      flags &= ~(F_LEFT | F_RIGHT);
      go_scene(0);
    end
    w.gesture = g;
    w.main_on = flags[0]; w.extra_on = flags[1]; w.sos_on = flags[2];
    w.left_on = flags[3]; w.right_on = flags[4];
    w.lamp_lit = lit;
    w.level = bright[7:0];
    w.scene = (flags & F_SOS) ? 2'd3 : (flags & F_LEFT) ? 2'd1 :
              (flags & F_RIGHT) ? 2'd2 : scene_st;
    return w;
  endfunction

  task automatic gap(int most_short);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
        $urandom_range(0, most_short);
    if (n != 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_tick(logic [1:0] lv, bit chk, lamp_word_t want, bit idle);
    lamp_word_t p;
    if (idle) gap(1);
    in_tdata <= {6'd0, lv};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_tick(lv);
    if (chk && p != want) begin
      failed = 1;
      if (mismatches < 10) $display("directed row mismatch: table %h predictor %h", want, p);
      mismatches++;
    end
    expected_words.push_back(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic hold_run(int n, logic [1:0] lv, bit idle);
    repeat (n) send_tick(lv, 0, '0, idle);
  endtask

  task automatic gesture_burst();
    int k, b, n;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      // presses on one or both buttons, then release long enough to end it
      n = $urandom_range(1, 4);
      b = $urandom_range(1, 3);
      repeat (n) begin
        hold_run($urandom_range(1, 5), ~b[1:0], 1);
        hold_run($urandom_range(1, 5), 2'b11, 1);
      end
      if ($urandom_range(0, 4) == 0) hold_run(hold_t + 2, ~b[1:0], 1);
      hold_run(gap_t + 2, 2'b11, $urandom_range(0, 3) == 0);
    end else begin
      repeat ($urandom_range(1, 20)) send_tick(2'($urandom_range(0, 3)), 0, '0, 1);
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random back-pressure plus one long hold-off window.
  initial begin
    out_tready = 0;
    hold_off = 0;
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_tready <= 1'b0;
      else out_tready <= 1'b1;
    end
  end

  initial begin
    wait (rst_n);
    repeat (300) @(negedge clk);
    hold_off = 1;
    repeat (200) @(negedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    lamp_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[19:0];
      if (expected_words.size() == 0) begin
        failed = 1;
        if (mismatches < 10) $display("unexpected word %h", got);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (got != want || out_tdata[23:20] != 0) begin
          failed = 1;
          if (mismatches < 10)
            $display("word mismatch: g %0d/%0d flags %b/%b lit %b/%b lvl %0d/%0d sc %0d/%0d",
                     want.gesture, got.gesture,
                     {want.main_on, want.extra_on, want.sos_on, want.left_on, want.right_on},
                     {got.main_on, got.extra_on, got.sos_on, got.left_on, got.right_on},
                     want.lamp_lit, got.lamp_lit, want.level, got.level,
                     want.scene, got.scene);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int i, wait_n;
    lamp_word_t idle_w;
    rst_n = 0; in_tvalid = 0; in_tdata = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    mismatches = 0; failed = 0;
    reset_model();
    repeat (4) @(negedge clk);
    rst_n = 1;

    // Directed: short gap and hold so gestures finish within the table.
    write_reg(R_HOLD, 16'd3);
    write_reg(R_GAP, 16'd2);
    idle_w = '0;
    idle_w.level = 8'd100;
    rows.push_back('{2'b11, 1, idle_w});
    rows.push_back('{2'b11, 1, idle_w});
    // single left press: left turn
    rows.push_back('{2'b10, 0, '0});
    for (i = 0; i < 4; i++) rows.push_back('{2'b11, 0, '0});
    // both pressed once: main toggle
    rows.push_back('{2'b00, 0, '0});
    for (i = 0; i < 4; i++) rows.push_back('{2'b11, 0, '0});
    // right held: lighter
    for (i = 0; i < 6; i++) rows.push_back('{2'b01, 0, '0});
    rows.push_back('{2'b11, 0, '0});
    // four left presses: invalid
    for (i = 0; i < 4; i++) begin
      rows.push_back('{2'b10, 0, '0});
      rows.push_back('{2'b11, 0, '0});
    end
    for (i = 0; i < rows.size(); i++) send_tick(rows[i].lv, rows[i].chk, rows[i].want, 0);
    drain();

    // Triple presses on both: SOS, then double presses on each side, then a triple left press.
    for (i = 0; i < 3; i++) begin hold_run(1, 2'b00, 0); hold_run(1, 2'b11, 0); end
    hold_run(5, 2'b11, 0);
    for (i = 0; i < 2; i++) begin hold_run(1, 2'b01, 0); hold_run(1, 2'b11, 0); end
    hold_run(5, 2'b11, 0);
    for (i = 0; i < 2; i++) begin hold_run(1, 2'b10, 0); hold_run(1, 2'b11, 0); end
    hold_run(5, 2'b11, 0);
    for (i = 0; i < 3; i++) begin hold_run(1, 2'b10, 0); hold_run(1, 2'b11, 0); end
    hold_run(5, 2'b11, 0);
    drain();

    // Settings: defaults-like, small, extremes, a write to an unused index, and one more mix.
    for (wait_n = 0; wait_n < 5; wait_n++) begin
      case (wait_n)
        0: begin
          write_reg(R_HOLD, 16'd8); write_reg(R_GAP, 16'd6);
          write_reg(R_BON, 16'd3); write_reg(R_BOFF, 16'd2);
          write_reg(R_TOUT, 16'd60); write_reg(R_STEP, 16'd30);
        end
        1: begin
          write_reg(R_HOLD, 16'd1); write_reg(R_GAP, 16'd1);
          write_reg(R_BON, 16'd1); write_reg(R_BOFF, 16'd0);
          write_reg(R_TOUT, 16'd1); write_reg(R_STEP, 16'd255);
        end
        2: begin
          write_reg(R_HOLD, 16'd5); write_reg(R_GAP, 16'd4);
          write_reg(R_BON, 16'h7FFF); write_reg(R_BOFF, 16'h7FFF);
          write_reg(R_TOUT, 16'hFFFF); write_reg(R_STEP, 16'd0);
        end
        3: begin
          write_reg(R_HOLD, 16'd12); write_reg(R_GAP, 16'd9);
          write_reg(R_BON, 16'd0); write_reg(R_BOFF, 16'd5);
          write_reg(R_TOUT, 16'd200); write_reg(R_STEP, 16'd77);
          write_reg(3'd7, 16'hFFFF);
        end
        default: begin
          write_reg(R_HOLD, 16'd4); write_reg(R_GAP, 16'd3);
          write_reg(R_BON, 16'd7); write_reg(R_BOFF, 16'd9);
          write_reg(R_TOUT, 16'd90); write_reg(R_STEP, 16'd15);
        end
      endcase
      i = 0;
      while (i < 225) begin
        gesture_burst();
        i += 15;
      end
      if (wait_n == 2) begin
        gap(2);
        drain();
      end
      drain();
    end

    if (!failed) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
